// ===== src/ffba_pkg.sv =====
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int unsigned MaxBlocksDef   = 64;
  localparam int unsigned HeaderBytesDef = 48;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_FREE    = 2'd2,
    OP_REALLOC = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_FULL    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_SMALL   = 3'd4
  } status_t;

  typedef enum logic {
    CFG_REGION_BASE = 1'b0,
    CFG_AREA_BYTES  = 1'b1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FIND_RD,    // issue read of entry idx
    S_FIND_WT,    // read data registered
    S_FIND_CHK,
    S_ALLOC_RD,
    S_ALLOC_WT,
    S_ALLOC_CHK,
    S_SHR_RD,     // shift entries up one slot (from top down)
    S_SHR_WT,
    S_SHR_WR,
    S_SPLIT_WR,
    S_FREE_NX_RD,
    S_FREE_NX_WT,
    S_FREE_NX_CHK,
    S_FREE_PV_RD,
    S_FREE_PV_WT,
    S_FREE_PV_CHK,
    S_SHL_RD,     // shift entries down one slot
    S_SHL_WT,
    S_SHL_WR,
    S_DONE
  } state_t;

endpackage

// ===== src/ffba_ram.sv =====
`timescale 1ns / 1ps
module ffba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// Init goes straight to done; other ops walk the table, reading each entry visited,
// and a split or merge also shifts the entries that follow the target by one slot.
// Throughput: one request at a time; the table RAM port (one read, one write per
// cycle) bounds the walk. Result sits in an output register until transferred.
// Reset (rst_n, synchronous, active low) clears block count, state, the two config
// registers and the result valid flag; table RAM contents are left undefined.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS   = MaxBlocksDef,
  parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_request_bytes,
  input  logic [31:0] in_payload_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_address,
  output logic [2:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned EW = 65;  // free mark, size, offset
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_BLOCKS);
  localparam logic [31:0] Hdr = 32'(HEADER_BYTES);

  state_t st_r, st_nxt;
  logic [31:0] base_r, area_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;   // walk position
  logic [CW-1:0] tgt_r, tgt_nxt;   // entry found by lookup
  logic [CW-1:0] end_r, end_nxt;   // shift limit
  logic [1:0] op_r;
  logic [31:0] req_r, ptr_r;
  logic merged_r, merged_nxt;      // next-neighbour merge happened, or split target write pending
  logic [EW-1:0] cur_r, cur_nxt;   // held entry (target)
  logic [31:0] addr_r, addr_nxt;
  status_t stat_r, stat_nxt;
  logic ov_r, ov_nxt;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  ffba_ram #(.Width(EW), .Depth(MAX_BLOCKS)) u_tab (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic        rd_free;
  logic [31:0] rd_size, rd_off, rd_pay;
  logic [32:0] need;
  assign rd_free = rdata[64];
  assign rd_size = rdata[63:32];
  assign rd_off  = rdata[31:0];
  assign rd_pay  = base_r + rd_off + Hdr;
  assign need    = {1'b0, req_r} + {1'b0, Hdr};

  assign in_stall  = (st_r != S_IDLE) || ov_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_result_address = addr_r;
  assign out_status = stat_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          unique case (op_t'(in_op))
            OP_INIT:  st_nxt = S_DONE;
            OP_ALLOC: st_nxt = S_ALLOC_RD;
            OP_FREE, OP_REALLOC: begin
              if (in_payload_address == '0)
                st_nxt = (op_t'(in_op) == OP_FREE) ? S_DONE : S_ALLOC_RD;
              else st_nxt = S_FIND_RD;
            end
            default: st_nxt = S_DONE;
          endcase
        end
      end
      S_FIND_RD: st_nxt = (idx_r >= cnt_r) ? S_DONE : S_FIND_WT;
      S_FIND_WT: st_nxt = S_FIND_CHK;
      S_FIND_CHK: begin
        if (rd_pay == ptr_r) begin
          if (op_r == OP_REALLOC) st_nxt = (rd_size >= req_r) ? S_DONE : S_ALLOC_RD;
          else st_nxt = S_FREE_NX_RD;
        end else st_nxt = S_FIND_RD;
      end
      S_ALLOC_RD: st_nxt = (idx_r >= cnt_r) ? S_DONE : S_ALLOC_WT;
      S_ALLOC_WT: st_nxt = S_ALLOC_CHK;
      S_ALLOC_CHK: begin
        if (rd_free && rd_size >= req_r) begin
          if ({1'b0, rd_size} > need && cnt_r < MaxCnt) st_nxt = S_SHR_RD;
          else st_nxt = S_DONE;
        end else st_nxt = S_ALLOC_RD;
      end
      S_SHR_RD:      st_nxt = (idx_r > tgt_r + CW'(1)) ? S_SHR_WT : S_SPLIT_WR;
      S_SHR_WT:      st_nxt = S_SHR_WR;
      S_SHR_WR:      st_nxt = S_SHR_RD;
      S_SPLIT_WR:    st_nxt = S_DONE;
      S_FREE_NX_RD:  st_nxt = (idx_r < cnt_r) ? S_FREE_NX_WT : S_FREE_PV_RD;
      S_FREE_NX_WT:  st_nxt = S_FREE_NX_CHK;
      S_FREE_NX_CHK: st_nxt = rd_free ? S_SHL_RD : S_FREE_PV_RD;
      S_FREE_PV_RD:  st_nxt = (tgt_r != '0) ? S_FREE_PV_WT : S_DONE;
      S_FREE_PV_WT:  st_nxt = S_FREE_PV_CHK;
      S_FREE_PV_CHK: st_nxt = rd_free ? S_SHL_RD : S_DONE;
      S_SHL_RD: begin
        if (end_r + CW'(1) < cnt_r) st_nxt = S_SHL_WT;
        else st_nxt = merged_r ? S_FREE_PV_RD : S_DONE;
      end
      S_SHL_WT: st_nxt = S_SHL_WR;
      S_SHL_WR: st_nxt = S_SHL_RD;
      S_DONE:   st_nxt = S_IDLE;
      default:  st_nxt = S_IDLE;
    endcase
  end

  // datapath and table port
  always_comb begin
    cnt_nxt = cnt_r; idx_nxt = idx_r; tgt_nxt = tgt_r;
    end_nxt = end_r; merged_nxt = merged_r; cur_nxt = cur_r;
    addr_nxt = addr_r; stat_nxt = stat_r; ov_nxt = ov_r;
    we = 1'b0; waddr = idx_r[IW-1:0]; wdata = cur_r; raddr = idx_r[IW-1:0];
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          addr_nxt = '0; stat_nxt = ST_OK; idx_nxt = '0; merged_nxt = 1'b0;
          if (op_t'(in_op) == OP_INIT) begin
            if (base_r == '0 || area_r < Hdr) begin
              stat_nxt = ST_SMALL;
            end else begin
              we = 1'b1; waddr = '0; wdata = {1'b1, area_r - Hdr, 32'd0};
              cnt_nxt = CW'(1);
            end
          end
        end
      end
      S_FIND_RD: begin
        if (idx_r >= cnt_r) stat_nxt = ST_UNKNOWN;
      end
      S_FIND_CHK: begin
        if (rd_pay == ptr_r) begin
          cur_nxt = rdata; tgt_nxt = idx_r;
          if (op_r == OP_REALLOC) begin
            if (rd_size >= req_r) addr_nxt = ptr_r;
            else idx_nxt = '0;
          end else begin
            cur_nxt[64] = 1'b1;
            idx_nxt = idx_r + CW'(1);
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_ALLOC_RD: begin
        if (idx_r >= cnt_r) stat_nxt = ST_NOFIT;
      end
      S_ALLOC_CHK: begin
        if (rd_free && rd_size >= req_r) begin
          tgt_nxt = idx_r; cur_nxt = rdata;
          if ({1'b0, rd_size} > need) begin
            if (cnt_r >= MaxCnt) stat_nxt = ST_FULL;
            else idx_nxt = cnt_r;
          end else begin
            we = 1'b1; wdata = {1'b0, rdata[63:0]};
            addr_nxt = rd_pay;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      // move entry idx-1 to idx while idx > tgt+1
      S_SHR_RD: begin
        if (idx_r > tgt_r + CW'(1)) raddr = IW'(idx_r - CW'(1));
      end
      S_SHR_WT: raddr = IW'(idx_r - CW'(1));
      S_SHR_WR: begin
        we = 1'b1; wdata = rdata; idx_nxt = idx_r - CW'(1);
      end
      S_SPLIT_WR: begin
        // new remainder at tgt+1, then shrink target
        we = 1'b1; waddr = IW'(tgt_r + CW'(1));
        wdata = {1'b1, cur_r[63:32] - need[31:0], cur_r[31:0] + need[31:0]};
        cur_nxt = {1'b0, req_r, cur_r[31:0]};
        cnt_nxt = cnt_r + CW'(1);
        addr_nxt = base_r + cur_r[31:0] + Hdr;
        idx_nxt = tgt_r;
        merged_nxt = 1'b1;  // flags pending target write in DONE
      end
      S_FREE_NX_RD: raddr = IW'(idx_r);
      S_FREE_NX_CHK: begin
        if (rd_free) begin
          cur_nxt[63:32] = cur_r[63:32] + Hdr + rd_size;
          end_nxt = idx_r;  // remove idx
          merged_nxt = 1'b1;
        end
      end
      S_FREE_PV_RD: begin
        we = 1'b1; waddr = IW'(tgt_r); wdata = cur_r;
        raddr = IW'(tgt_r - CW'(1));
        merged_nxt = 1'b0;
      end
      S_FREE_PV_WT: raddr = IW'(tgt_r - CW'(1));
      S_FREE_PV_CHK: begin
        if (rd_free) begin
          we = 1'b1; waddr = IW'(tgt_r - CW'(1));
          wdata = {1'b1, rd_size + Hdr + cur_r[63:32], rd_off};
          cur_nxt = {1'b1, rd_size + Hdr + cur_r[63:32], rd_off};
          tgt_nxt = tgt_r - CW'(1);
          end_nxt = tgt_r;
        end
      end
      // remove entry end: move end+1.. down one
      S_SHL_RD: begin
        if (end_r + CW'(1) < cnt_r) raddr = IW'(end_r + CW'(1));
        else cnt_nxt = cnt_r - CW'(1);
      end
      S_SHL_WT: raddr = IW'(end_r + CW'(1));
      S_SHL_WR: begin
        we = 1'b1; waddr = IW'(end_r); wdata = rdata;
        end_nxt = end_r + CW'(1);
      end
      S_DONE: begin
        if (merged_r && op_r != OP_FREE) begin
          we = 1'b1; waddr = IW'(tgt_r); wdata = cur_r;
        end
        merged_nxt = 1'b0;
        ov_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; ov_r <= 1'b0; merged_r <= 1'b0;
      base_r <= '0; area_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt; merged_r <= merged_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_REGION_BASE: base_r <= cfg_data;
          CFG_AREA_BYTES:  area_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; tgt_r <= tgt_nxt; end_r <= end_nxt; cur_r <= cur_nxt;
    addr_r <= addr_nxt; stat_r <= stat_nxt;
    if (st_r == S_IDLE && in_valid && !in_stall) begin
      op_r <= in_op; req_r <= in_request_bytes; ptr_r <= in_payload_address;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MaxCnt)
    else $error("block count over table size");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE) |=> out_valid) else $error("result not posted");
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_result_address == '0)
    else $error("address on failure");
endmodule
